### rtl/core/bmprs_pkg.sv
`default_nettype none

package bmprs_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_DIM_DEF    = 256;
    localparam int SCALE_FRAC_DEF = 8;

    // Fixed field widths
    localparam int DIM_CFG_W   = 9;
    localparam int ORIGIN_W    = 11;
    localparam int SCALE_W     = 12;
    localparam int PIX_W       = 13;
    localparam int SIDE_W      = 4;
    localparam int CFG_DATA_W  = 12;
    localparam int CFG_INDEX_W = 3;
    localparam int RUN_W       = 4;

    // Coordinate limits
    localparam int COORD_MAX = 4095;
    localparam int COORD_MIN = -4096;
    localparam int OFF_MAX   = 6143;
    localparam int MAX_SIDE  = 8;

    // Descriptor queue depth (power of two)
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_IMAGE_WIDTH  = 3'd0,
        CFG_IMAGE_HEIGHT = 3'd1,
        CFG_DEPTH_MODE   = 3'd2,
        CFG_FLIP_ROWS    = 3'd3,
        CFG_ORIGIN_X     = 3'd4,
        CFG_ORIGIN_Y     = 3'd5,
        CFG_SCALE_Q      = 3'd6
    } bmprs_cfg_idx_t;

    typedef struct packed {
        logic [DIM_CFG_W-1:0]       image_width;
        logic [DIM_CFG_W-1:0]       image_height;
        logic                       depth_mode;
        logic                       flip_rows;
        logic signed [ORIGIN_W-1:0] origin_x;
        logic signed [ORIGIN_W-1:0] origin_y;
        logic [SCALE_W-1:0]         scale_q;
    } bmprs_cfg_t;

    typedef struct packed {
        logic depth_mode;
        logic ends_image;
    } bmprs_flags_t;

endpackage

`default_nettype wire

### rtl/core/bmprs_fifo.sv
`default_nettype none

module bmprs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = bmprs_pkg::QUEUE_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             pop,
    output logic                  valid,
    output logic [WIDTH-1:0]      rd_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign valid   = (count_reg != '0);
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

### rtl/core/bmprs_front.sv
`default_nettype none

module bmprs_front #(
    parameter int MAX_DIM = bmprs_pkg::MAX_DIM_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire bmprs_pkg::bmprs_cfg_t            cfg,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic                             start_of_image,
    input  wire logic [7:0]                       data_byte,
    input  wire logic                             q_full,
    output logic                                  q_push,
    output logic [$clog2(MAX_DIM)-1:0]            d_first_col,
    output logic [$clog2(MAX_DIM)-1:0]            d_dest_row,
    output logic [bmprs_pkg::RUN_W-1:0]           d_count,
    output logic [7:0]                            d_data,
    output bmprs_pkg::bmprs_flags_t               d_flags
);

    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int IDX_W  = $clog2(MAX_DIM);
    localparam int RB_MAX = ((MAX_DIM + 3) / 4) * 4;
    localparam int BW     = $clog2(RB_MAX);
    localparam int CALC_W = BW + 4;
    localparam int EXT_W  = (DIM_W > bmprs_pkg::DIM_CFG_W) ? DIM_W : bmprs_pkg::DIM_CFG_W;
    localparam int RUN_W  = bmprs_pkg::RUN_W;

    logic [BW-1:0]     byte_in_row_reg, byte_in_row_next;
    logic [IDX_W-1:0]  rows_left_reg, rows_left_next;

    logic [EXT_W-1:0]  w_raw, h_raw;
    logic [DIM_W-1:0]  w, h;
    logic [IDX_W-1:0]  h_max, rows_pos, row, dest_row;
    logic [BW-1:0]     byte_pos;
    logic [CALC_W-1:0] w_c, pos_c, row_bytes, first_col, remain;
    logic [RUN_W-1:0]  run_len;
    logic              accept;

    // Clamp the dimensions to 1..MAX_DIM
    assign w_raw = EXT_W'(cfg.image_width);
    assign h_raw = EXT_W'(cfg.image_height);
    assign w = (w_raw == '0) ? DIM_W'(1) :
               (w_raw > EXT_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(w_raw);
    assign h = (h_raw == '0) ? DIM_W'(1) :
               (h_raw > EXT_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(h_raw);
    assign h_max = IDX_W'(h - DIM_W'(1));

    // A start mark restarts the image before this byte is decoded
    assign byte_pos = start_of_image ? '0 : byte_in_row_reg;
    assign rows_pos = start_of_image ? h_max : rows_left_reg;
    assign row      = (rows_pos > h_max) ? h_max : rows_pos;
    assign dest_row = cfg.flip_rows ? (h_max - row) : row;

    assign w_c   = CALC_W'(w);
    assign pos_c = CALC_W'(byte_pos);

    // Rows are padded to 4 bytes
    assign row_bytes = cfg.depth_mode ? (((w_c + CALC_W'(3)) >> 2) << 2)
                                      : (((w_c + CALC_W'(31)) >> 5) << 2);
    assign first_col = cfg.depth_mode ? pos_c : (pos_c << 3);
    assign remain    = w_c - first_col;

    always_comb
    begin
        run_len = '0;
        if ((pos_c < row_bytes) && (first_col < w_c))
        begin
            if (cfg.depth_mode)
            begin
                run_len = RUN_W'(1);
            end
            else if (remain > CALC_W'(8))
            begin
                run_len = RUN_W'(8);
            end
            else
            begin
                run_len = RUN_W'(remain);
            end
        end
    end

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    // Drop padding and bytes past the row width
    assign q_push   = accept && (run_len != '0);

    assign d_first_col        = IDX_W'(first_col);
    assign d_dest_row         = dest_row;
    assign d_count            = run_len;
    assign d_data             = data_byte;
    assign d_flags.depth_mode = cfg.depth_mode;
    assign d_flags.ends_image = (row == '0) && ((first_col + CALC_W'(run_len)) == w_c);

    // Inside a row keep the stored row index as is; it is clamped where it is used
    always_comb
    begin
        byte_in_row_next = byte_in_row_reg;
        rows_left_next   = rows_left_reg;
        if (accept)
        begin
            if ((pos_c + CALC_W'(1)) >= row_bytes)
            begin
                byte_in_row_next = '0;
                rows_left_next   = (row == '0) ? h_max : (row - IDX_W'(1));
            end
            else
            begin
                byte_in_row_next = BW'(pos_c + CALC_W'(1));
                rows_left_next   = rows_pos;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_in_row_reg <= '0;
            rows_left_reg   <= '0;
        end
        else
        begin
            byte_in_row_reg <= byte_in_row_next;
            rows_left_reg   <= rows_left_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/bmprs_back.sv
`default_nettype none

module bmprs_back #(
    parameter int MAX_DIM         = bmprs_pkg::MAX_DIM_DEF,
    parameter int SCALE_FRAC_BITS = bmprs_pkg::SCALE_FRAC_DEF
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire bmprs_pkg::bmprs_cfg_t                  cfg,
    input  wire logic                                   q_valid,
    output logic                                        q_pop,
    input  wire logic [$clog2(MAX_DIM)-1:0]             q_first_col,
    input  wire logic [$clog2(MAX_DIM)-1:0]             q_dest_row,
    input  wire logic [bmprs_pkg::RUN_W-1:0]            q_count,
    input  wire logic [7:0]                             q_data,
    input  wire bmprs_pkg::bmprs_flags_t                q_flags,
    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output logic signed [bmprs_pkg::PIX_W-1:0]          pixel_x,
    output logic signed [bmprs_pkg::PIX_W-1:0]          pixel_y,
    output logic [bmprs_pkg::SIDE_W-1:0]                block_side,
    output logic                                        color,
    output logic                                        last_in_run,
    output logic                                        last_of_image
);

    localparam int IDX_W  = $clog2(MAX_DIM);
    localparam int PROD_W = IDX_W + bmprs_pkg::SCALE_W;
    localparam int OFF_W  = PROD_W - SCALE_FRAC_BITS;
    localparam int PIX_W  = bmprs_pkg::PIX_W;
    localparam int SUM_W  = PIX_W + 1;
    localparam int RUN_W  = bmprs_pkg::RUN_W;
    localparam int SIDE_W = bmprs_pkg::SIDE_W;

    // origin + trunc(coord * scale), saturated
    function automatic logic [PIX_W-1:0] place(
        input logic signed [bmprs_pkg::ORIGIN_W-1:0] base,
        input logic [PROD_W-1:0]                     prod
    );
        logic [OFF_W-1:0]        off;
        logic [31:0]             off_ext;
        logic [PIX_W-1:0]        off_sat;
        logic signed [SUM_W-1:0] sum;
        off     = prod[PROD_W-1:SCALE_FRAC_BITS];
        off_ext = 32'(off);
        off_sat = (off_ext > 32'(bmprs_pkg::OFF_MAX)) ? PIX_W'(bmprs_pkg::OFF_MAX)
                                                      : off_ext[PIX_W-1:0];
        sum = $signed({{(SUM_W - bmprs_pkg::ORIGIN_W){base[bmprs_pkg::ORIGIN_W-1]}}, base})
            + $signed({1'b0, off_sat});
        if (sum > $signed(SUM_W'(bmprs_pkg::COORD_MAX)))
        begin
            sum = $signed(SUM_W'(bmprs_pkg::COORD_MAX));
        end
        else if (sum < $signed(SUM_W'(bmprs_pkg::COORD_MIN)))
        begin
            sum = $signed(SUM_W'(bmprs_pkg::COORD_MIN));
        end
        return sum[PIX_W-1:0];
    endfunction

    // Run iterator
    logic                    cur_valid_reg, cur_valid_next;
    logic [2:0]              k_reg, k_next;
    logic [IDX_W-1:0]        cur_first_col_reg, cur_dest_row_reg;
    logic [RUN_W-1:0]        cur_count_reg;
    logic [7:0]              cur_data_reg;
    bmprs_pkg::bmprs_flags_t cur_flags_reg;

    // Multiply stage
    logic                    m_valid_reg;
    logic [PROD_W-1:0]       m_prod_x_reg, m_prod_y_reg;
    logic                    m_color_reg, m_last_run_reg, m_last_img_reg;

    // Output register
    logic                    out_valid_reg;
    logic [PIX_W-1:0]        pixel_x_reg, pixel_y_reg;
    logic [SIDE_W-1:0]       side_reg;
    logic                    color_reg, last_run_reg, last_img_reg;

    logic                    en, is_last, elem_color;
    logic [IDX_W-1:0]        col;
    logic [31:0]             side_full;
    logic [SIDE_W-1:0]       side;

    assign en      = !out_valid_reg || out_ready;
    assign is_last = ((RUN_W'(k_reg) + RUN_W'(1)) == cur_count_reg);
    assign q_pop   = q_valid && (!cur_valid_reg || (en && is_last));

    assign col        = cur_first_col_reg + IDX_W'(k_reg);
    assign elem_color = cur_flags_reg.depth_mode ? cur_data_reg[7]
                                                 : cur_data_reg[3'd7 - k_reg];

    // ceil(scale), kept within 1..8
    assign side_full = (32'(cfg.scale_q) + 32'((1 << SCALE_FRAC_BITS) - 1)) >> SCALE_FRAC_BITS;
    assign side = (side_full == '0) ? SIDE_W'(1) :
                  (side_full > 32'(bmprs_pkg::MAX_SIDE)) ? SIDE_W'(bmprs_pkg::MAX_SIDE)
                                                         : SIDE_W'(side_full);

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        k_next         = k_reg;
        if (q_pop)
        begin
            cur_valid_next = 1'b1;
            k_next         = '0;
        end
        else if (en && cur_valid_reg)
        begin
            if (is_last)
            begin
                cur_valid_next = 1'b0;
            end
            else
            begin
                k_next = k_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            k_reg         <= '0;
            m_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            k_reg         <= k_next;
            if (en)
            begin
                m_valid_reg   <= cur_valid_reg;
                out_valid_reg <= m_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_first_col_reg <= q_first_col;
            cur_dest_row_reg  <= q_dest_row;
            cur_count_reg     <= q_count;
            cur_data_reg      <= q_data;
            cur_flags_reg     <= q_flags;
        end
        if (en)
        begin
            m_prod_x_reg   <= PROD_W'(col) * PROD_W'(cfg.scale_q);
            m_prod_y_reg   <= PROD_W'(cur_dest_row_reg) * PROD_W'(cfg.scale_q);
            m_color_reg    <= elem_color;
            m_last_run_reg <= is_last;
            m_last_img_reg <= is_last && cur_flags_reg.ends_image;

            pixel_x_reg  <= place(cfg.origin_x, m_prod_x_reg);
            pixel_y_reg  <= place(cfg.origin_y, m_prod_y_reg);
            side_reg     <= side;
            color_reg    <= m_color_reg;
            last_run_reg <= m_last_run_reg;
            last_img_reg <= m_last_img_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign pixel_x       = $signed(pixel_x_reg);
    assign pixel_y       = $signed(pixel_y_reg);
    assign block_side    = side_reg;
    assign color         = color_reg;
    assign last_in_run   = last_run_reg;
    assign last_of_image = last_img_reg;

endmodule

`default_nettype wire

### rtl/core/bmp_row_to_scaled_mono_pixels_unit.sv
// Decodes the pixel-data bytes of a bottom-up 1-bit or 8-bit BMP into one
// item per visible pixel: the scaled display corner (origin + trunc(coord *
// scale), saturated to -4096..4095), the square block side ceil(scale) in
// 1..8, the color and run/image end marks. Bytes are taken one per cycle
// while the four-entry run queue between the byte decoder and the pixel
// generator has room; padding bytes and bytes past the row width leave no
// trace in the queue. The pixel generator sends one pixel item per cycle
// while out_ready is high; a byte carries up to 8 pixels in 1-bit mode and
// 1 in 8-bit mode, so the pixel generator sets the sustained rate. Once its
// run reaches the head of the queue, a pixel passes the iterator, multiplier
// and saturating-adder registers in order. Write configuration only while no
// item is in flight; write row geometry before the first byte of an image and
// mark that byte with start_of_image.
`default_nettype none

module bmp_row_to_scaled_mono_pixels_unit #(
    parameter int MAX_DIM         = bmprs_pkg::MAX_DIM_DEF,
    parameter int SCALE_FRAC_BITS = bmprs_pkg::SCALE_FRAC_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // configuration write port
    input  wire logic                                  cfg_we,
    input  wire logic [bmprs_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [bmprs_pkg::CFG_DATA_W-1:0]      cfg_data,
    // byte input
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic                                  start_of_image,
    input  wire logic [7:0]                            data_byte,
    // pixel output
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic signed [bmprs_pkg::PIX_W-1:0]         pixel_x,
    output logic signed [bmprs_pkg::PIX_W-1:0]         pixel_y,
    output logic [bmprs_pkg::SIDE_W-1:0]               block_side,
    output logic                                       color,
    output logic                                       last_in_run,
    output logic                                       last_of_image
);

    localparam int IDX_W = $clog2(MAX_DIM);
    localparam int RUN_W = bmprs_pkg::RUN_W;
    localparam int Q_W   = 2 * IDX_W + RUN_W + 8 + $bits(bmprs_pkg::bmprs_flags_t);

    // Configuration registers
    bmprs_pkg::bmprs_cfg_t cfg_reg, cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (bmprs_pkg::bmprs_cfg_idx_t'(cfg_index))
                bmprs_pkg::CFG_IMAGE_WIDTH:
                    cfg_next.image_width = cfg_data[bmprs_pkg::DIM_CFG_W-1:0];
                bmprs_pkg::CFG_IMAGE_HEIGHT:
                    cfg_next.image_height = cfg_data[bmprs_pkg::DIM_CFG_W-1:0];
                bmprs_pkg::CFG_DEPTH_MODE:
                    cfg_next.depth_mode = cfg_data[0];
                bmprs_pkg::CFG_FLIP_ROWS:
                    cfg_next.flip_rows = cfg_data[0];
                bmprs_pkg::CFG_ORIGIN_X:
                    cfg_next.origin_x = $signed(cfg_data[bmprs_pkg::ORIGIN_W-1:0]);
                bmprs_pkg::CFG_ORIGIN_Y:
                    cfg_next.origin_y = $signed(cfg_data[bmprs_pkg::ORIGIN_W-1:0]);
                bmprs_pkg::CFG_SCALE_Q:
                    cfg_next.scale_q = cfg_data[bmprs_pkg::SCALE_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    // Reset to a 1x1 image, 1-bit mode, no flip, origin 0, scale 1.0
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width  <= bmprs_pkg::DIM_CFG_W'(1);
            cfg_reg.image_height <= bmprs_pkg::DIM_CFG_W'(1);
            cfg_reg.depth_mode   <= 1'b0;
            cfg_reg.flip_rows    <= 1'b0;
            cfg_reg.origin_x     <= '0;
            cfg_reg.origin_y     <= '0;
            cfg_reg.scale_q      <= bmprs_pkg::SCALE_W'(256);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: byte decoder to run descriptor
    logic                    q_push, q_full, q_pop, q_valid;
    logic [IDX_W-1:0]        d_first_col, d_dest_row, r_first_col, r_dest_row;
    logic [RUN_W-1:0]        d_count, r_count;
    logic [7:0]              d_data, r_data;
    bmprs_pkg::bmprs_flags_t d_flags, r_flags;
    logic [Q_W-1:0]          q_wr_data, q_rd_data;

    bmprs_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .start_of_image (start_of_image),
        .data_byte      (data_byte),
        .q_full         (q_full),
        .q_push         (q_push),
        .d_first_col    (d_first_col),
        .d_dest_row     (d_dest_row),
        .d_count        (d_count),
        .d_data         (d_data),
        .d_flags        (d_flags)
    );

    // Run queue: lets the decoder run ahead while pixels drain
    assign q_wr_data = {d_first_col, d_dest_row, d_count, d_data, d_flags};
    assign {r_first_col, r_dest_row, r_count, r_data, r_flags} = q_rd_data;

    bmprs_fifo #(
        .WIDTH (Q_W),
        .DEPTH (bmprs_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (q_wr_data),
        .full    (q_full),
        .pop     (q_pop),
        .valid   (q_valid),
        .rd_data (q_rd_data)
    );

    // Back: one pixel per cycle while out_ready is high, scaled and saturated
    bmprs_back #(
        .MAX_DIM         (MAX_DIM),
        .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .q_valid       (q_valid),
        .q_pop         (q_pop),
        .q_first_col   (r_first_col),
        .q_dest_row    (r_dest_row),
        .q_count       (r_count),
        .q_data        (r_data),
        .q_flags       (r_flags),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .block_side    (block_side),
        .color         (color),
        .last_in_run   (last_in_run),
        .last_of_image (last_of_image)
    );

    // The decoder never writes a run into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("run queue overflow");

    // The image end mark only comes on the last pixel of a byte
    a_image_end_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last_of_image) |-> last_in_run)
        else $error("last_of_image without last_in_run");

    // Block side stays within 1..8
    a_side_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((block_side != '0) &&
                       (block_side <= bmprs_pkg::SIDE_W'(bmprs_pkg::MAX_SIDE))))
        else $error("block_side out of range");

endmodule

`default_nettype wire
